// File: rtl/text_console_writer_core_assert.svh
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is applied
`define TCW_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is applied
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int FUNC_W = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int DATA_W = 16;
	localparam int ATTR_W = 8;

	localparam int TAB_STEP = 8;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;
	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

	// function codes
	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// control characters
	localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

	typedef enum logic [2:0] {
		CMD_PRINT,
		CMD_BS,
		CMD_TAB,
		CMD_CR,
		CMD_LF,
		CMD_NOP,
		CMD_CLEAR,
		CMD_READ
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_position;
		logic [DATA_W-1:0] cell_data;
	} res_t;

	typedef struct packed {
		logic init;
		logic cmd_pop;
		logic res_push;
	} back_stat_t;

	typedef enum logic [1:0] {
		BST_FILL,
		BST_IDLE,
		BST_READ,
		BST_BLANK
	} bst_t;

	localparam int QUEUE_DEPTH = 2;

endpackage

// File: rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// text-mode console: character output, clear and cell read over queue ports
// ----------------------------------------------------------------------------
// characters, clear and unused operations pass the command queue, the engine and the
//   result queue, a cell read also rd_q and the BST_READ state; two-entry queues on both sides
// throughput: one character per cycle, set by the single screen port, while no scroll,
//   clear or full result queue stalls it; a scroll blanks one row of COLUMNS cells, a clear
//   all ROWS*COLUMNS cells; after reset the screen is filled with 0x0F20, full high meanwhile
module text_console_writer_core #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        text_attribute_we,
	input  logic [tcw_pkg::ATTR_W-1:0]  text_attribute,
	input  logic                        push,
	output logic                        full,
	input  logic [tcw_pkg::FUNC_W-1:0]  func,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
	output logic                        empty,
	input  logic                        pop,
	output logic [tcw_pkg::POS_W-1:0]   cursor_position,
	output logic [tcw_pkg::DATA_W-1:0]  cell_data
);

`include "text_console_writer_core_assert.svh"

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic                       cmd_push;
	tcw_pkg::cmd_t              cmd_in;
	tcw_pkg::cmd_t              cmd_head;
	logic                       cmd_full;
	logic                       cmd_empty;
	tcw_pkg::res_t              res_in;
	tcw_pkg::res_t              res_head;
	logic                       res_full;
	tcw_pkg::back_stat_t        bst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (text_attribute_we) begin
			attr_q <= text_attribute;
		end
	end

	// no transactions taken during the power-up fill
	assign full = cmd_full || bst.init;

	tcw_front u_front (
		.push       (push),
		.full       (full),
		.func       (func),
		.char_code  (char_code),
		.cell_index (cell_index),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in)
	);

	tcw_queue #(
		.WIDTH ($bits(tcw_pkg::cmd_t))
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.pop    (bst.cmd_pop),
		.rdata  (cmd_head),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	tcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      (attr_q),
		.cmd       (cmd_head),
		.cmd_valid (!cmd_empty),
		.res_ready (!res_full),
		.res       (res_in),
		.stat      (bst)
	);

	tcw_queue #(
		.WIDTH ($bits(tcw_pkg::res_t))
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bst.res_push),
		.wdata  (res_in),
		.pop    (pop && !empty),
		.rdata  (res_head),
		.full   (res_full),
		.empty  (empty)
	);

	assign cursor_position = res_head.cursor_position;
	assign cell_data       = res_head.cell_data;

	// result space is reserved when a command leaves the command queue
	`TCW_ASSERT_IMPLY(a_res_space, clk, arst_n, bst.res_push, !res_full)
	`TCW_ASSERT_IMPLY(a_cmd_pop_valid, clk, arst_n, bst.cmd_pop, !cmd_empty)
	`TCW_ASSERT_IMPLY(a_init_no_pop, clk, arst_n, bst.init, !bst.cmd_pop)
	`TCW_ASSERT_NEXT(a_res_visible, clk, arst_n, bst.res_push, !empty)

endmodule

// File: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// small register queue used on both sides of the execution engine
// ----------------------------------------------------------------------------
module tcw_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   cnt_q;

	assign full  = (cnt_q == (PTR_W+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// takes input transactions and sorts them into console commands
// ----------------------------------------------------------------------------
module tcw_front (
	input  logic                        push,
	input  logic                        full,
	input  logic [tcw_pkg::FUNC_W-1:0]  func,
	input  logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcw_pkg::IDX_W-1:0]   cell_index,
	output logic                        cmd_push,
	output tcw_pkg::cmd_t               cmd
);

	tcw_pkg::cmd_op_t char_op;

	assign cmd_push = push && !full;

	always_comb begin
		unique case (char_code)
			tcw_pkg::CH_BS:  char_op = tcw_pkg::CMD_BS;
			tcw_pkg::CH_TAB: char_op = tcw_pkg::CMD_TAB;
			tcw_pkg::CH_CR:  char_op = tcw_pkg::CMD_CR;
			tcw_pkg::CH_LF:  char_op = tcw_pkg::CMD_LF;
			default: begin
				// other control bytes leave everything alone
				if (char_code >= tcw_pkg::BLANK_CHAR) begin
					char_op = tcw_pkg::CMD_PRINT;
				end else begin
					char_op = tcw_pkg::CMD_NOP;
				end
			end
		endcase
	end

	always_comb begin
		cmd.char_code  = char_code;
		cmd.cell_index = cell_index;
		unique case (func)
			tcw_pkg::FUNC_PUT:   cmd.op = char_op;
			tcw_pkg::FUNC_CLEAR: cmd.op = tcw_pkg::CMD_CLEAR;
			tcw_pkg::FUNC_READ:  cmd.op = tcw_pkg::CMD_READ;
			default:             cmd.op = tcw_pkg::CMD_NOP;
		endcase
	end

endmodule

// File: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// executes console commands against the screen memory and the cursor
// ----------------------------------------------------------------------------
module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tcw_pkg::ATTR_W-1:0] attr,
	input  tcw_pkg::cmd_t              cmd,
	input  logic                       cmd_valid,
	input  logic                       res_ready,
	output tcw_pkg::res_t              res,
	output tcw_pkg::back_stat_t        stat
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int CMP_W      = (ADDR_W > tcw_pkg::IDX_W ? ADDR_W : tcw_pkg::IDX_W) + 1;

	logic [tcw_pkg::DATA_W-1:0] screen_q [CELL_COUNT];

	tcw_pkg::bst_t state_q, state_d;
	logic [COL_W-1:0]           col_q, col_d;
	logic [ROW_W-1:0]           row_q, row_d;
	logic [ADDR_W-1:0]          base_q, base_d;
	logic [ADDR_W-1:0]          cnt_q, cnt_d;
	logic [tcw_pkg::DATA_W-1:0] blank_q, blank_d;
	logic                       init_q, init_d;
	logic                       rd_ok_q, rd_ok_d;
	logic [tcw_pkg::DATA_W-1:0] rd_q;

	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [tcw_pkg::DATA_W-1:0] mem_wdata;
	logic                       rd_en;

	logic [ADDR_W-1:0]          cur_lin;
	logic [ADDR_W:0]            cur_sum;
	logic [ADDR_W-1:0]          phys_cur;
	logic [ADDR_W:0]            idx_sum;
	logic [ADDR_W-1:0]          phys_idx;
	logic                       idx_ok;
	logic [ADDR_W:0]            base_sum;
	logic [ADDR_W-1:0]          base_next;
	logic [COL_W:0]             ncol_ext;
	logic [ROW_W:0]             nrow_ext;
	logic [ADDR_W-1:0]          new_lin;
	logic [tcw_pkg::DATA_W-1:0] blank_now;
	logic                       cmd_pop;
	logic                       res_push;

	// screen rows rotate: base_q is the physical cell of logical row zero
	assign cur_lin  = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(col_q);
	assign cur_sum  = {1'b0, cur_lin} + {1'b0, base_q};
	assign phys_cur = (cur_sum >= (ADDR_W+1)'(CELL_COUNT))
		? ADDR_W'(cur_sum - (ADDR_W+1)'(CELL_COUNT)) : cur_sum[ADDR_W-1:0];

	assign idx_ok   = CMP_W'(cmd.cell_index) < CMP_W'(CELL_COUNT);
	assign idx_sum  = {1'b0, ADDR_W'(cmd.cell_index)} + {1'b0, base_q};
	assign phys_idx = (idx_sum >= (ADDR_W+1)'(CELL_COUNT))
		? ADDR_W'(idx_sum - (ADDR_W+1)'(CELL_COUNT)) : idx_sum[ADDR_W-1:0];

	assign base_sum  = {1'b0, base_q} + (ADDR_W+1)'(COLUMNS);
	assign base_next = (base_sum >= (ADDR_W+1)'(CELL_COUNT)) ? '0 : base_sum[ADDR_W-1:0];

	assign blank_now = {attr, tcw_pkg::BLANK_CHAR};

	always_comb begin
		state_d   = state_q;
		col_d     = col_q;
		row_d     = row_q;
		base_d    = base_q;
		cnt_d     = cnt_q;
		blank_d   = blank_q;
		init_d    = init_q;
		rd_ok_d   = rd_ok_q;
		mem_we    = 1'b0;
		mem_waddr = phys_cur;
		mem_wdata = blank_q;
		rd_en     = 1'b0;
		cmd_pop   = 1'b0;
		res_push  = 1'b0;
		ncol_ext  = {1'b0, col_q};
		nrow_ext  = {1'b0, row_q};
		new_lin   = cur_lin;
		res.cursor_position = tcw_pkg::POS_W'(cur_lin);
		res.cell_data       = '0;

		unique case (state_q)
			tcw_pkg::BST_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
					cnt_d   = '0;
					init_d  = 1'b0;
					state_d = tcw_pkg::BST_IDLE;
				end
			end
			tcw_pkg::BST_BLANK: begin
				// old top row becomes the new bottom row
				mem_we    = 1'b1;
				mem_waddr = base_q + cnt_q;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
					cnt_d   = '0;
					base_d  = base_next;
					state_d = tcw_pkg::BST_IDLE;
				end
			end
			tcw_pkg::BST_READ: begin
				res_push      = 1'b1;
				res.cell_data = rd_ok_q ? rd_q : '0;
				state_d       = tcw_pkg::BST_IDLE;
			end
			tcw_pkg::BST_IDLE: begin
				if (cmd_valid && res_ready) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						tcw_pkg::CMD_CLEAR: begin
							col_d    = '0;
							row_d    = '0;
							base_d   = '0;
							cnt_d    = '0;
							blank_d  = blank_now;
							state_d  = tcw_pkg::BST_FILL;
							res_push = 1'b1;
							res.cursor_position = '0;
						end
						tcw_pkg::CMD_READ: begin
							rd_en   = 1'b1;
							rd_ok_d = idx_ok;
							state_d = tcw_pkg::BST_READ;
						end
						default: begin
							case (cmd.op)
								tcw_pkg::CMD_PRINT: begin
									mem_we    = 1'b1;
									mem_waddr = phys_cur;
									mem_wdata = {attr, cmd.char_code};
									ncol_ext  = {1'b0, col_q} + 1'b1;
								end
								tcw_pkg::CMD_BS: begin
									if (col_q != '0) begin
										ncol_ext = {1'b0, col_q} - 1'b1;
									end
								end
								tcw_pkg::CMD_TAB: begin
									ncol_ext = ({1'b0, col_q} + (COL_W+1)'(tcw_pkg::TAB_STEP))
										& ~(COL_W+1)'(tcw_pkg::TAB_STEP - 1);
								end
								tcw_pkg::CMD_CR: begin
									ncol_ext = '0;
								end
								tcw_pkg::CMD_LF: begin
									ncol_ext = '0;
									nrow_ext = {1'b0, row_q} + 1'b1;
								end
								default: begin
									ncol_ext = {1'b0, col_q};
								end
							endcase
							// wrap at line end
							if (ncol_ext >= (COL_W+1)'(COLUMNS)) begin
								ncol_ext = '0;
								nrow_ext = nrow_ext + 1'b1;
							end
							// past the last row: scroll one row
							if (nrow_ext >= (ROW_W+1)'(ROWS)) begin
								nrow_ext = (ROW_W+1)'(ROWS - 1);
								blank_d  = blank_now;
								cnt_d    = '0;
								state_d  = tcw_pkg::BST_BLANK;
							end
							col_d    = ncol_ext[COL_W-1:0];
							row_d    = nrow_ext[ROW_W-1:0];
							new_lin  = ADDR_W'(row_d) * ADDR_W'(COLUMNS) + ADDR_W'(col_d);
							res_push = 1'b1;
							res.cursor_position = tcw_pkg::POS_W'(new_lin);
						end
					endcase
				end
			end
			default: begin
				state_d = tcw_pkg::BST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_q[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= screen_q[phys_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::BST_FILL;
			col_q   <= '0;
			row_q   <= '0;
			base_q  <= '0;
			cnt_q   <= '0;
			blank_q <= {tcw_pkg::ATTR_RESET, tcw_pkg::BLANK_CHAR};
			init_q  <= 1'b1;
			rd_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
			blank_q <= blank_d;
			init_q  <= init_d;
			rd_ok_q <= rd_ok_d;
		end
	end

	assign stat.init     = init_q;
	assign stat.cmd_pop  = cmd_pop;
	assign stat.res_push = res_push;

endmodule

// File: dv/text_console_writer_core_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_core_tb
// drives character, clear, read and unused operations through the queue
// ports, predicts cursor and cell contents on a shadow screen, and checks
// every result transaction in order under random sender gaps and pop stalls
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;

	localparam int SCREEN_COLS = tcw_pkg::COLUMNS_DEF;
	localparam int SCREEN_ROWS = tcw_pkg::ROWS_DEF;
	localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int REPORT_MAX  = 10;

	localparam logic [tcw_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam logic [tcw_pkg::DATA_W-1:0] RESET_CELL  = 16'h0F20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_attribute_we = 1'b0;
	logic [tcw_pkg::ATTR_W-1:0] text_attribute = '0;
	logic push = 1'b0;
	logic full;
	logic [tcw_pkg::FUNC_W-1:0] func = '0;
	logic [tcw_pkg::CHAR_W-1:0] char_code = '0;
	logic [tcw_pkg::IDX_W-1:0] cell_index = '0;
	logic empty;
	logic pop = 1'b0;
	logic [tcw_pkg::POS_W-1:0] cursor_position;
	logic [tcw_pkg::DATA_W-1:0] cell_data;

	text_console_writer_core #(
		.COLUMNS(SCREEN_COLS),
		.ROWS(SCREEN_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_attribute_we(text_attribute_we),
		.text_attribute(text_attribute),
		.push(push),
		.full(full),
		.func(func),
		.char_code(char_code),
		.cell_index(cell_index),
		.empty(empty),
		.pop(pop),
		.cursor_position(cursor_position),
		.cell_data(cell_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the console state
	logic [tcw_pkg::DATA_W-1:0] shadow_cells [CELLS];
	int unsigned shadow_col;
	int unsigned shadow_row;
	logic [tcw_pkg::ATTR_W-1:0] shadow_attr;

	tcw_pkg::res_t expected_results [$];
	int mismatch_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit push_high = 1'b0;

	int pop_mode = 0;
	int pop_run = 0;
	bit pop_next;
	tcw_pkg::res_t wanted;

	function automatic logic [tcw_pkg::DATA_W-1:0] blank_with_attr();
		return {shadow_attr, tcw_pkg::BLANK_CHAR};
	endfunction

	function automatic void scroll_shadow();
		for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
			shadow_cells[i] = shadow_cells[i + SCREEN_COLS];
		for (int i = 0; i < SCREEN_COLS; i++)
			shadow_cells[(SCREEN_ROWS - 1) * SCREEN_COLS + i] = blank_with_attr();
		shadow_row = SCREEN_ROWS - 1;
	endfunction

	function automatic void put_char_shadow(logic [tcw_pkg::CHAR_W-1:0] ch);
		if (ch == tcw_pkg::CH_BS) begin
			if (shadow_col != 0)
				shadow_col--;
		end else if (ch == tcw_pkg::CH_TAB) begin
			shadow_col = (shadow_col / tcw_pkg::TAB_STEP + 1) * tcw_pkg::TAB_STEP;
		end else if (ch == tcw_pkg::CH_CR) begin
			shadow_col = 0;
		end else if (ch == tcw_pkg::CH_LF) begin
			shadow_col = 0;
			shadow_row++;
		end else if (ch >= tcw_pkg::BLANK_CHAR) begin
			shadow_cells[shadow_row * SCREEN_COLS + shadow_col] = {shadow_attr, ch};
			shadow_col++;
		end
		// other control bytes leave everything alone
		if (shadow_col >= SCREEN_COLS) begin
			shadow_col = 0;
			shadow_row++;
		end
		if (shadow_row >= SCREEN_ROWS)
			scroll_shadow();
	endfunction

	function automatic tcw_pkg::res_t predict_console(logic [tcw_pkg::FUNC_W-1:0] f,
			logic [tcw_pkg::CHAR_W-1:0] ch, logic [tcw_pkg::IDX_W-1:0] idx);
		tcw_pkg::res_t r;
		int unsigned lin;
		r.cell_data = '0;
		case (f)
			tcw_pkg::FUNC_PUT: put_char_shadow(ch);
			tcw_pkg::FUNC_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					shadow_cells[i] = blank_with_attr();
				shadow_col = 0;
				shadow_row = 0;
			end
			tcw_pkg::FUNC_READ: begin
				if (idx < CELLS)
					r.cell_data = shadow_cells[idx];
			end
			default: ;
		endcase
		lin = shadow_row * SCREEN_COLS + shadow_col;
		r.cursor_position = lin[tcw_pkg::POS_W-1:0];
		return r;
	endfunction

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endfunction

	// result side: check each popped transaction, then drive the stall pattern
	always @(posedge clk) begin : result_check
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				note_mismatch($sformatf("unexpected result pos=%0d data=%h",
					cursor_position, cell_data));
			end else begin
				wanted = expected_results.pop_front();
				if (cursor_position !== wanted.cursor_position)
					note_mismatch($sformatf("cursor_position expected %0d got %0d",
						wanted.cursor_position, cursor_position));
				if (cell_data !== wanted.cell_data)
					note_mismatch($sformatf("cell_data expected %h got %h",
						wanted.cell_data, cell_data));
			end
		end
		if (pop_run == 0) begin
			pop_mode = $urandom_range(0, 3);
			pop_run = $urandom_range(20, 200);
		end else begin
			pop_run--;
		end
		case (pop_mode)
			0: pop_next = 1'b1;
			1: pop_next = 1'($urandom_range(0, 1));
			2: pop_next = ($urandom_range(0, 7) == 0);
			default: pop_next = ((cycle_count % 16) < 12);
		endcase
		pop <= pop_next;
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL text_console_writer_core");
			$finish;
		end
	end

	task automatic lower_push();
		if (push_high) begin
			push <= 1'b0;
			push_high = 1'b0;
		end
	endtask

	task automatic hold_off(int cycles);
		lower_push();
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		lower_push();
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// a scroll or clear may still be running after its result has gone out
	task automatic settle();
		drain_results();
		repeat (CELLS + 100) @(posedge clk);
	endtask

	task automatic send_cmd(logic [tcw_pkg::FUNC_W-1:0] f, logic [tcw_pkg::CHAR_W-1:0] ch,
			logic [tcw_pkg::IDX_W-1:0] idx);
		push <= 1'b1;
		push_high = 1'b1;
		func <= f;
		char_code <= ch;
		cell_index <= idx;
		@(posedge clk);
		while (full) @(posedge clk);
		expected_results.push_back(predict_console(f, ch, idx));
		items_sent++;
		if (burst_left == 0) begin
			hold_off($urandom_range(1, 6));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	task automatic put_char(logic [tcw_pkg::CHAR_W-1:0] ch);
		send_cmd(tcw_pkg::FUNC_PUT, ch, tcw_pkg::IDX_W'($urandom_range(0, 2047)));
	endtask

	task automatic read_cell(logic [tcw_pkg::IDX_W-1:0] idx);
		send_cmd(tcw_pkg::FUNC_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)), idx);
	endtask

	task automatic clear_screen();
		send_cmd(tcw_pkg::FUNC_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
			tcw_pkg::IDX_W'($urandom_range(0, 2047)));
	endtask

	task automatic write_attribute(logic [tcw_pkg::ATTR_W-1:0] value);
		text_attribute_we <= 1'b1;
		text_attribute <= value;
		@(posedge clk);
		text_attribute_we <= 1'b0;
		shadow_attr = value;
	endtask

	task automatic test_reset_state();
		read_cell(11'd0);
		read_cell(tcw_pkg::IDX_W'(CELLS - 1));
		read_cell(11'h7FF);
	endtask

	task automatic test_printable();
		put_char(tcw_pkg::BLANK_CHAR);
		put_char(8'h7F);
		put_char(8'hFF);
		read_cell(11'd2);
	endtask

	task automatic test_controls();
		put_char(tcw_pkg::CH_BS);
		put_char(tcw_pkg::CH_CR);
		put_char(tcw_pkg::CH_BS);
		put_char(8'h00);
		put_char(8'h1F);
		send_cmd(FUNC_UNUSED, 8'hFF, 11'h7FF);
		put_char(tcw_pkg::CH_LF);
	endtask

	// ten tabs from column zero: the last one runs off the line end
	task automatic test_tab_wrap();
		repeat (10) put_char(tcw_pkg::CH_TAB);
	endtask

	task automatic test_clear();
		clear_screen();
		read_cell(11'd1);
	endtask

	task automatic send_text_line();
		int len;
		int term;
		len = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 20);
		repeat (len) put_char(tcw_pkg::CHAR_W'($urandom_range(32, 255)));
		term = $urandom_range(0, 9);
		if (term <= 6) begin
			put_char(tcw_pkg::CH_LF);
		end else if (term == 7) begin
			put_char(tcw_pkg::CH_CR);
		end else if (term == 8) begin
			put_char(tcw_pkg::CH_CR);
			put_char(tcw_pkg::CH_LF);
		end
	endtask

	task automatic send_reads();
		int p;
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 7))
				0: read_cell(tcw_pkg::IDX_W'($urandom_range(CELLS, 2047)));
				1, 2, 3: begin
					p = shadow_row * SCREEN_COLS + shadow_col - $urandom_range(0, 90);
					if (p < 0)
						p = 0;
					read_cell(tcw_pkg::IDX_W'(p));
				end
				default: read_cell(tcw_pkg::IDX_W'($urandom_range(0, CELLS - 1)));
			endcase
		end
	endtask

	task automatic send_noise();
		logic [tcw_pkg::FUNC_W-1:0] f;
		repeat ($urandom_range(1, 4)) begin
			f = tcw_pkg::FUNC_W'($urandom_range(0, 3));
			// keep clears rare, each one walks the whole screen
			if (f == tcw_pkg::FUNC_CLEAR)
				f = FUNC_UNUSED;
			send_cmd(f, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
				tcw_pkg::IDX_W'($urandom_range(0, 2047)));
		end
	endtask

	task automatic test_random_traffic(int count);
		int target;
		int kind;
		target = items_sent + count;
		clear_screen();
		while (items_sent < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				send_text_line();
			end else if (kind < 55) begin
				repeat ($urandom_range(1, 12)) begin
					if ($urandom_range(0, 3) == 0)
						put_char(tcw_pkg::CHAR_W'($urandom_range(32, 255)));
					put_char(tcw_pkg::CH_TAB);
				end
			end else if (kind < 65) begin
				if ($urandom_range(0, 2) == 0)
					put_char(tcw_pkg::CH_CR);
				repeat ($urandom_range(1, 6)) put_char(tcw_pkg::CH_BS);
			end else if (kind < 85) begin
				send_reads();
			end else if (kind < 96) begin
				send_noise();
			end else begin
				clear_screen();
			end
			if ($urandom_range(0, 39) == 0)
				drain_results();
		end
	endtask

	initial begin
		for (int i = 0; i < CELLS; i++)
			shadow_cells[i] = RESET_CELL;
		shadow_col = 0;
		shadow_row = 0;
		shadow_attr = tcw_pkg::ATTR_RESET;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the screen fill after reset
		@(posedge clk);
		while (full) @(posedge clk);

		test_reset_state();
		test_printable();
		test_controls();
		test_tab_wrap();
		test_clear();

		settle();
		write_attribute(8'h00);
		test_random_traffic(270);
		settle();
		write_attribute(8'hFF);
		test_random_traffic(270);
		settle();
		write_attribute(tcw_pkg::ATTR_W'($urandom_range(0, 255)));
		test_random_traffic(270);
		settle();
		write_attribute(tcw_pkg::ATTR_W'($urandom_range(0, 255)));
		test_random_traffic(260);
		settle();
		write_attribute(tcw_pkg::ATTR_RESET);
		test_random_traffic(260);
		settle();
		write_attribute(tcw_pkg::ATTR_W'($urandom_range(0, 255)));
		test_random_traffic(260);

		settle();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("PASS text_console_writer_core");
		end else begin
			$display("FAIL text_console_writer_core");
		end
		$finish;
	end

endmodule
